// ----- design/replica_backoff_delay_table_macros.svh -----
// ----------------------------------------------------------------------------
// Replica backoff delay table: assertion macros
// Shared property forms for the checker, clocked and gated by reset.
// ----------------------------------------------------------------------------
`ifndef REPLICA_BACKOFF_DELAY_TABLE_MACROS_SVH
`define REPLICA_BACKOFF_DELAY_TABLE_MACROS_SVH

// Same-cycle implication
`define RBDT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define RBDT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rbdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Replica backoff delay table: package
// Payload types, register indexes, operation codes and shared constants.
// ----------------------------------------------------------------------------
package rbdt_pkg;

  // Default number of slot entries
  localparam int RBDT_MAX_SLOTS_DEF = 32;

  // Field widths
  localparam int RBDT_SLOT_W    = 5;
  localparam int RBDT_RING_W    = 6;
  localparam int RBDT_DELAY_W   = 16;
  localparam int RBDT_HASH_W    = 32;
  localparam int RBDT_SUM_W     = 21;
  localparam int RBDT_CFG_IDX_W = 2;
  localparam int RBDT_CFG_DATA_W = 16;

  // Operation codes
  typedef enum logic [1:0] {
    MODE_SUM     = 2'd0,
    MODE_SICK    = 2'd1,
    MODE_HEALTHY = 2'd2,
    MODE_PRIO    = 2'd3
  } rbdt_mode_t;

  // Configuration register indexes
  typedef enum logic [RBDT_CFG_IDX_W-1:0] {
    REG_OWN_SLOT   = 2'd0,
    REG_RING_SIZE  = 2'd1,
    REG_INIT_DELAY = 2'd2,
    REG_FLOOR      = 2'd3
  } rbdt_reg_t;

  // Input item
  typedef struct packed {
    rbdt_mode_t             mode;
    logic [RBDT_SLOT_W-1:0] slot;
    logic [RBDT_HASH_W-1:0] priority_hash;
    logic [RBDT_SLOT_W-1:0] other_slot;
  } rbdt_in_t;

  // Result item
  typedef struct packed {
    logic [RBDT_SUM_W-1:0] delay_sum;
    logic                  other_first;
    logic                  bad_index;
  } rbdt_out_t;

  // Delay store controls
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_one;
    logic clr_all;
  } rbdt_mem_ctl_t;

endpackage

// ----- design/rbdt_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Replica backoff delay table: modulo unit
// Restoring remainder of a 32-bit hash by the ring size, one bit a cycle.
// ----------------------------------------------------------------------------
module rbdt_mod_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [rbdt_pkg::RBDT_HASH_W-1:0] dividend,
  input  logic [rbdt_pkg::RBDT_RING_W-1:0] divisor,
  output logic                           done,
  output logic [rbdt_pkg::RBDT_RING_W-1:0] rem
);
  import rbdt_pkg::*;

  localparam int CNT_W = $clog2(RBDT_HASH_W);

  logic                   busy_r;
  logic                   done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [RBDT_HASH_W-1:0] quo_r;
  logic [RBDT_RING_W-1:0] div_r;
  logic [RBDT_RING_W-1:0] rem_r;
  logic [RBDT_RING_W:0]   trial;
  logic [RBDT_RING_W-1:0] rem_nxt;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_r, quo_r[RBDT_HASH_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = RBDT_RING_W'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = RBDT_RING_W'(trial);
    end
  end

  // Control: run for one step per dividend bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RBDT_HASH_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[RBDT_HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- design/rbdt_delay_mem.sv -----
// ----------------------------------------------------------------------------
// Replica backoff delay table: delay store
// One delay per slot with registered read; an entry without its valid bit
// reads as the current initial delay, so reloads are a clear of valid bits.
// ----------------------------------------------------------------------------
module rbdt_delay_mem #(
  parameter int MAX_SLOTS = rbdt_pkg::RBDT_MAX_SLOTS_DEF,
  parameter int IDX_W     = $clog2(MAX_SLOTS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rbdt_pkg::rbdt_mem_ctl_t          ctl,
  input  logic [IDX_W-1:0]                 addr,
  input  logic [rbdt_pkg::RBDT_DELAY_W-1:0] wr_data,
  input  logic [rbdt_pkg::RBDT_DELAY_W-1:0] init_delay,
  output logic [rbdt_pkg::RBDT_DELAY_W-1:0] rd_data
);
  import rbdt_pkg::*;

  logic [RBDT_DELAY_W-1:0] delay_mem_r [MAX_SLOTS];
  logic [MAX_SLOTS-1:0]    valid_r;
  logic [MAX_SLOTS-1:0]    valid_nxt;
  logic [RBDT_DELAY_W-1:0] rd_q_r;
  logic                    rd_vld_r;

  // Update valid bits: clear all on reload, set on write, clear on single reload
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clr_all) begin
      valid_nxt = '0;
    end else begin
      if (ctl.wr_en) begin
        valid_nxt[addr] = 1'b1;
      end
      if (ctl.clr_one) begin
        valid_nxt[addr] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      delay_mem_r[addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_r   <= delay_mem_r[addr];
      rd_vld_r <= valid_r[addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : init_delay;

endmodule

// ----- design/replica_backoff_delay_table.sv -----
// ----------------------------------------------------------------------------
// Replica backoff delay table
// Per-slot wait delays on a ring of replicas, walked by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one item at a time; one
//   result leaves on the output channel (out_valid/out_stall/out_data) for
//   every item. in_stall is high from the transfer of an item until its
//   result is loaded into the output register.
//   Steps per item:
//     sum and halve: a read of the single-port delay store, then an add or
//       a write-back, for each walked slot
//     priority check: the bit-serial modulo unit, then a walk of the slots
//       without the store; single reload or flagged index: straight to result
//   The result sits in the output register while out_stall is high; the next
//   item may be taken meanwhile, and its result waits until the register frees.
//   Synchronous reset (rst_n low) restores the register defaults and marks
//   every delay entry as holding the initial delay; no clearing pass needed.
//   Configuration writes (cfg_we/cfg_index/cfg_data) are registered and
//   are expected only while the block is idle.
// ----------------------------------------------------------------------------
module replica_backoff_delay_table #(
  parameter int MAX_SLOTS = rbdt_pkg::RBDT_MAX_SLOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rbdt_pkg::rbdt_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rbdt_pkg::rbdt_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [rbdt_pkg::RBDT_CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbdt_pkg::RBDT_CFG_DATA_W-1:0] cfg_data
);
  import rbdt_pkg::*;

  localparam int IDX_W    = $clog2(MAX_SLOTS);
  localparam int SW       = (IDX_W > RBDT_RING_W) ? IDX_W : RBDT_RING_W;
  localparam int RING_CAP = (MAX_SLOTS < (1 << RBDT_RING_W)) ? MAX_SLOTS
                                                            : (1 << RBDT_RING_W) - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EXEC,
    ST_PRIO,
    ST_DONE
  } state_t;

  // Configuration registers
  logic [RBDT_SLOT_W-1:0]  own_slot_r;
  logic [RBDT_RING_W-1:0]  ring_size_r;
  logic [RBDT_DELAY_W-1:0] init_delay_r;
  logic [RBDT_DELAY_W-1:0] floor_r;

  // Sequencer state
  state_t                  state_r,     state_nxt;
  rbdt_mode_t              mode_r,      mode_nxt;
  logic [RBDT_SLOT_W-1:0]  other_r,     other_nxt;
  logic [SW-1:0]           ptr_r,       ptr_nxt;
  logic [RBDT_SUM_W-1:0]   sum_r,       sum_nxt;
  logic                    first_r,     first_nxt;
  logic                    bad_r,       bad_nxt;
  logic                    out_valid_r, out_valid_nxt;
  rbdt_out_t               out_data_r,  out_data_nxt;

  logic [RBDT_RING_W-1:0]  ring_eff;
  logic [SW-1:0]           own_ext;
  logic [SW-1:0]           ptr_inc;
  logic [SW-1:0]           ptr_next;
  logic                    accept;
  logic                    slot_bad;
  logic                    own_bad;
  logic                    other_bad;
  logic [RBDT_DELAY_W-1:0] rd_data;
  logic [RBDT_DELAY_W-1:0] half_delay;
  logic [RBDT_DELAY_W-1:0] wr_data;
  logic [IDX_W-1:0]        mem_addr;
  rbdt_mem_ctl_t           mem_ctl;
  logic                    mod_start;
  logic                    mod_done;
  logic [RBDT_RING_W-1:0]  mod_rem;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_slot_r   <= '0;
      ring_size_r  <= RBDT_RING_W'(1);
      init_delay_r <= RBDT_DELAY_W'(64);
      floor_r      <= RBDT_DELAY_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_SLOT:   own_slot_r   <= cfg_data[RBDT_SLOT_W-1:0];
        REG_RING_SIZE:  ring_size_r  <= cfg_data[RBDT_RING_W-1:0];
        REG_INIT_DELAY: init_delay_r <= cfg_data[RBDT_DELAY_W-1:0];
        REG_FLOOR:      floor_r      <= cfg_data[RBDT_DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring size saturates at the number of entries, or at 63 if the ring field cannot hold it
  assign ring_eff = (ring_size_r > RBDT_RING_W'(RING_CAP)) ? RBDT_RING_W'(RING_CAP)
                                                            : ring_size_r;

  // Index checks against the ring size
  assign slot_bad  = RBDT_RING_W'(in_data.slot) >= ring_eff;
  assign own_bad   = RBDT_RING_W'(own_slot_r) >= ring_eff;
  assign other_bad = RBDT_RING_W'(in_data.other_slot) >= ring_eff;

  // Step the walk pointer with wrap at the ring size
  assign own_ext  = SW'(own_slot_r);
  assign ptr_inc  = ptr_r + 1'b1;
  assign ptr_next = (ptr_inc >= SW'(ring_eff)) ? '0 : ptr_inc;

  // Halve a delay, floored
  assign half_delay = {1'b0, rd_data[RBDT_DELAY_W-1:1]};
  assign wr_data    = (half_delay < floor_r) ? floor_r : half_delay;

  assign accept = in_valid && !in_stall;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    other_nxt     = other_r;
    ptr_nxt       = ptr_r;
    sum_nxt       = sum_r;
    first_nxt     = first_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_ctl       = '0;
    mem_ctl.clr_all = cfg_we && (cfg_index == REG_INIT_DELAY);
    mem_addr      = ptr_r[IDX_W-1:0];
    mod_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_nxt  = in_data.mode;
          other_nxt = in_data.other_slot;
          sum_nxt   = '0;
          first_nxt = 1'b0;
          bad_nxt   = 1'b0;
          state_nxt = ST_DONE;
          case (in_data.mode)
            MODE_SUM, MODE_SICK: begin
              if (slot_bad || own_bad) begin
                bad_nxt = 1'b1;
              end else begin
                ptr_nxt   = SW'(in_data.slot);
                state_nxt = ST_READ;
              end
            end
            MODE_HEALTHY: begin
              if (slot_bad) begin
                bad_nxt = 1'b1;
              end else begin
                mem_ctl.clr_one = 1'b1;
                mem_addr        = IDX_W'(in_data.slot);
              end
            end
            MODE_PRIO: begin
              if (own_bad || other_bad) begin
                bad_nxt = 1'b1;
              end else begin
                mod_start = 1'b1;
                state_nxt = ST_MOD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          ptr_nxt   = SW'(mod_rem);
          state_nxt = ST_PRIO;
        end
      end
      ST_READ: begin
        if (ptr_r == own_ext) begin
          state_nxt = ST_DONE;
        end else begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mode_r == MODE_SUM) begin
          sum_nxt = sum_r + RBDT_SUM_W'(rd_data);
        end else begin
          mem_ctl.wr_en = 1'b1;
        end
        ptr_nxt   = ptr_next;
        state_nxt = ST_READ;
      end
      ST_PRIO: begin
        if (ptr_r == own_ext) begin
          state_nxt = ST_DONE;
        end else if (ptr_r == SW'(other_r)) begin
          first_nxt = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          ptr_nxt = ptr_next;
        end
      end
      ST_DONE: begin
        // Load the result once the output register is free or being drained
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.delay_sum   = sum_r;
          out_data_nxt.other_first = first_r;
          out_data_nxt.bad_index   = bad_r;
          out_valid_nxt            = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r     <= mode_nxt;
    other_r    <= other_nxt;
    ptr_r      <= ptr_nxt;
    sum_r      <= sum_nxt;
    first_r    <= first_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  rbdt_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (in_data.priority_hash),
    .divisor  (ring_eff),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  rbdt_delay_mem #(
    .MAX_SLOTS (MAX_SLOTS),
    .IDX_W     (IDX_W)
  ) u_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (mem_ctl),
    .addr       (mem_addr),
    .wr_data    (wr_data),
    .init_delay (init_delay_r),
    .rd_data    (rd_data)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- design/rbdt_checker.sv -----
// ----------------------------------------------------------------------------
// Replica backoff delay table: port checker
// Watches the channel ports of the top level over time.
// ----------------------------------------------------------------------------
`include "replica_backoff_delay_table_macros.svh"

module rbdt_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input rbdt_pkg::rbdt_in_t   in_data,
  input logic                 out_valid,
  input logic                 out_stall,
  input rbdt_pkg::rbdt_out_t  out_data
);

  // One item in flight: a transfer closes the input until its result is out
  `RBDT_ASSERT_NXT(a_busy_after_xfer, clk, rst_n, in_valid && !in_stall, in_stall,
    "input open right after a transfer")

  // A stalled result holds
  `RBDT_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_data), "stalled result changed or dropped")

  // A flagged index carries no other result
  `RBDT_ASSERT_IMP(a_bad_clean, clk, rst_n, out_valid && out_data.bad_index,
    out_data.delay_sum == '0 && !out_data.other_first, "flagged result not clean")

  // A priority answer never comes with a sum
  `RBDT_ASSERT_IMP(a_first_no_sum, clk, rst_n, out_valid && out_data.other_first,
    out_data.delay_sum == '0, "priority result carries a sum")

endmodule

bind replica_backoff_delay_table rbdt_checker u_rbdt_checker (.*);
